FILE: sv/dts_pkg.sv
`timescale 1ns / 1ps
package dts_pkg;
   localparam int DefMaxVertices = 64;
   localparam int DefMaxEdges    = 256;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_SORT  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] from_vertex;
      logic [5:0] to_vertex;
   } req_type;

   typedef struct packed {
      logic [5:0] vertex;
      logic       last;
      logic [1:0] status;
   } rsp_type;
endpackage

FILE: sv/dts_out_reg.sv
`timescale 1ns / 1ps
module dts_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  dts_pkg::rsp_type in_data,
   output logic             in_stall,
   output logic             out_valid,
   output dts_pkg::rsp_type out_data,
   input  logic             out_stall
);
   import dts_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
      if (!in_stall && in_valid) begin
         data_ff <= in_data;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && out_stall |=> valid_ff && $stable(data_ff))
      else $error("output register dropped a stalled transaction");
endmodule

FILE: sv/dts_core.sv
`timescale 1ns / 1ps
module dts_core #(
   parameter int MAX_VERTICES = dts_pkg::DefMaxVertices,
   parameter int MAX_EDGES    = dts_pkg::DefMaxEdges
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [6:0]       vertex_count,
   input  logic             req_valid,
   input  dts_pkg::req_type req_data,
   output logic             req_stall,
   output logic             res_valid,
   output dts_pkg::rsp_type res_data,
   input  logic             res_stall
);
   import dts_pkg::*;

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int EW = $clog2(MAX_EDGES);
   localparam int LW = EW + 1;        // link width, MAX_EDGES = null
   localparam int DW = VW + 1;        // depth / count width
   localparam logic [LW-1:0] NullLink = LW'(MAX_EDGES);

   typedef enum logic [3:0] {
      S_IDLE, S_ADD_RD, S_ADD_WR, S_CLEAR, S_ROOT, S_TOP, S_EDGE_RD, S_EDGE_USE,
      S_PUSH, S_EMIT_RD, S_EMIT, S_ACK
   } state_type;

   // memories
   logic [LW-1:0] head_mem   [MAX_VERTICES];
   logic [EW-1:0] tail_mem   [MAX_VERTICES];
   logic [LW-1:0] next_mem   [MAX_EDGES];
   logic [VW-1:0] target_mem [MAX_EDGES];
   logic [VW-1:0] snode_mem  [MAX_VERTICES];
   logic [LW-1:0] sedge_mem  [MAX_VERTICES];
   logic [VW-1:0] fin_mem    [MAX_VERTICES];

   logic [MAX_VERTICES-1:0] hvalid_ff;   // list_head valid; invalid = null
   logic [MAX_VERTICES-1:0] visited_ff;

   state_type     state_ff;
   logic [6:0]    eff_n;
   logic [LW:0]   total_ff;
   logic [DW-1:0] root_ff, depth_ff, done_ff, emit_ff;
   logic [VW-1:0] from_ff, to_ff, node_ff, tgt_ff;
   logic [LW-1:0] edge_ff, nxt_ff;
   logic [EW-1:0] tail_rd_ff;
   logic [VW-1:0] fin_rd_ff;
   rsp_type       res_ff;
   logic          res_valid_ff;

   assign eff_n = (vertex_count > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vertex_count;
   // a waiting result holds off the next transaction so res_ff is never overwritten
   assign req_stall = (state_ff != S_IDLE) || res_valid_ff;
   assign res_valid = res_valid_ff;
   assign res_data  = res_ff;

   logic [DW-1:0] top_idx;
   assign top_idx = depth_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         hvalid_ff    <= '0;
         visited_ff   <= '0;
         res_valid_ff <= 1'b0;
         depth_ff     <= '0;
      end else begin
         if (res_valid_ff && !res_stall && state_ff != S_ACK && state_ff != S_EMIT)
            res_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !res_valid_ff) begin
                  from_ff <= req_data.from_vertex[VW-1:0];
                  to_ff   <= req_data.to_vertex[VW-1:0];
                  unique case (mode_type'(req_data.mode))
                     MODE_ADD: begin
                        if (7'(req_data.from_vertex) >= eff_n ||
                            7'(req_data.to_vertex) >= eff_n) begin
                           res_ff <= '{vertex: '0, last: 1'b1, status: ST_RANGE};
                           state_ff <= S_ACK;
                        end else if (total_ff >= (LW+1)'(MAX_EDGES)) begin
                           res_ff <= '{vertex: '0, last: 1'b1, status: ST_FULL};
                           state_ff <= S_ACK;
                        end else begin
                           state_ff <= S_ADD_RD;
                        end
                     end
                     MODE_SORT: begin
                        visited_ff <= '0;
                        root_ff    <= '0;
                        done_ff    <= '0;
                        depth_ff   <= '0;
                        state_ff   <= S_ROOT;
                     end
                     MODE_CLEAR: state_ff <= S_CLEAR;
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_ADD_RD: begin
               target_mem[total_ff[EW-1:0]] <= to_ff;
               next_mem[total_ff[EW-1:0]]   <= NullLink;
               tail_rd_ff <= tail_mem[from_ff];
               state_ff   <= S_ADD_WR;
            end
            S_ADD_WR: begin
               // new edge goes to the list head or behind the old tail
               if (!hvalid_ff[from_ff]) begin
                  head_mem[from_ff]  <= total_ff[LW-1:0];
                  hvalid_ff[from_ff] <= 1'b1;
               end else begin
                  next_mem[tail_rd_ff] <= total_ff[LW-1:0];
               end
               tail_mem[from_ff] <= total_ff[EW-1:0];
               total_ff <= total_ff + 1'b1;
               res_ff   <= '{vertex: '0, last: 1'b1, status: ST_OK};
               state_ff <= S_ACK;
            end
            S_CLEAR: begin
               hvalid_ff <= '0;
               total_ff  <= '0;
               res_ff    <= '{vertex: '0, last: 1'b1, status: ST_OK};
               state_ff  <= S_ACK;
            end
            S_ACK: begin
               if (!res_valid_ff || !res_stall) begin
                  res_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_ROOT: begin
               if (7'(root_ff) >= eff_n) begin
                  emit_ff  <= '0;
                  state_ff <= (done_ff == '0) ? S_IDLE : S_EMIT_RD;
               end else if (visited_ff[root_ff[VW-1:0]]) begin
                  root_ff <= root_ff + 1'b1;
               end else begin
                  tgt_ff   <= root_ff[VW-1:0];
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               // push tgt_ff with its list head
               visited_ff[tgt_ff] <= 1'b1;
               node_ff  <= tgt_ff;
               edge_ff  <= hvalid_ff[tgt_ff] ? head_mem[tgt_ff] : NullLink;
               snode_mem[depth_ff[VW-1:0]] <= tgt_ff;
               depth_ff <= depth_ff + 1'b1;
               state_ff <= S_TOP;
            end
            S_TOP: begin
               // node_ff/edge_ff hold the top frame
               if (edge_ff == NullLink) begin
                  fin_mem[done_ff[VW-1:0]] <= node_ff;
                  done_ff  <= done_ff + 1'b1;
                  depth_ff <= top_idx;
                  if (top_idx == '0) begin
                     root_ff  <= root_ff + 1'b1;
                     state_ff <= S_ROOT;
                  end else begin
                     state_ff <= S_EDGE_RD;
                     nxt_ff   <= '1;   // marker: pop reload
                  end
               end else begin
                  nxt_ff   <= '0;
                  state_ff <= S_EDGE_RD;
               end
            end
            S_EDGE_RD: begin
               if (nxt_ff[0]) begin
                  // reload frame below after pop
                  node_ff  <= snode_mem[top_idx[VW-1:0]];
                  edge_ff  <= sedge_mem[top_idx[VW-1:0]];
                  state_ff <= S_TOP;
               end else begin
                  tgt_ff   <= target_mem[edge_ff[EW-1:0]];
                  nxt_ff   <= next_mem[edge_ff[EW-1:0]];
                  state_ff <= S_EDGE_USE;
               end
            end
            S_EDGE_USE: begin
               edge_ff <= nxt_ff;
               sedge_mem[top_idx[VW-1:0]] <= nxt_ff;
               if (7'(tgt_ff) < eff_n && !visited_ff[tgt_ff] &&
                   depth_ff < DW'(MAX_VERTICES))
                  state_ff <= S_PUSH;
               else
                  state_ff <= S_TOP;
            end
            S_EMIT_RD: begin
               fin_rd_ff <= fin_mem[VW'(done_ff - 1'b1 - emit_ff)];
               state_ff  <= S_EMIT;
            end
            S_EMIT: begin
               if (!res_valid_ff || !res_stall) begin
                  res_ff       <= '{vertex: 6'(fin_rd_ff),
                                    last: (emit_ff == done_ff - 1'b1),
                                    status: ST_OK};
                  res_valid_ff <= 1'b1;
                  emit_ff      <= emit_ff + 1'b1;
                  state_ff     <= (emit_ff == done_ff - 1'b1) ? S_IDLE : S_EMIT_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_depth: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_VERTICES))
      else $error("walk stack overflow");
   a_total: assert property (@(posedge clock) disable iff (reset)
      total_ff <= (LW+1)'(MAX_EDGES))
      else $error("edge count overflow");
   a_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUSH |-> !visited_ff[tgt_ff])
      else $error("vertex pushed twice");
endmodule

FILE: sv/dfs_topological_sort_unit.sv
`timescale 1ns / 1ps
// Add edge: the edge is appended to its source's list, and the status goes through the core's
// result register and the output register, as do clear and rejected-edge status. Sort: roots
// are scanned, edge lists walked on a vertex stack, finished vertices emitted in reverse.
// One transaction at a time; not ready while any transaction runs or a result waits.
// Synchronous active-high reset empties edge lists and sets vertex_count to 64.
module dfs_topological_sort_unit #(
   parameter int MAX_VERTICES = dts_pkg::DefMaxVertices,
   parameter int MAX_EDGES    = dts_pkg::DefMaxEdges
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  dts_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output dts_pkg::rsp_type rsp_data,
   input  logic             rsp_stall,
   input  logic             csr_valid,
   input  logic [6:0]       csr_data,
   output logic             csr_ready
);
   import dts_pkg::*;

   logic [6:0] vcount_ff;
   logic       mid_valid, mid_stall;
   rsp_type    mid_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 7'd64;
      end else if (csr_valid) begin
         vcount_ff <= csr_data;
      end
   end

   dts_core #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_core (
      .clock, .reset, .vertex_count(vcount_ff),
      .req_valid, .req_data, .req_stall,
      .res_valid(mid_valid), .res_data(mid_data), .res_stall(mid_stall)
   );

   dts_out_reg u_out (
      .clock, .reset,
      .in_valid(mid_valid), .in_data(mid_data), .in_stall(mid_stall),
      .out_valid(rsp_valid), .out_data(rsp_data), .out_stall(rsp_stall)
   );
endmodule
